// ===== hw/rtl/dpff_pkg.sv =====
// package: shared types and constants for the demand paging frame block
package dpff_pkg;
	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_ACCESS = 2'd1;
	localparam logic [1:0] MODE_FREE = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_FAULT_FREE = 3'd1;
	localparam logic [2:0] ST_FAULT_EVICT = 3'd2;
	localparam logic [2:0] ST_BAD_SIZE = 3'd3;
	localparam logic [2:0] ST_NO_PROC = 3'd4;
	localparam logic [2:0] ST_BAD_PAGE = 3'd5;

	localparam logic [0:0] REG_PAGE_LOG2 = 1'd0;
	localparam logic [0:0] REG_FRAMES = 1'd1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  process_slot;
		logic [16:0] alloc_bytes;
		logic [9:0]  page_number;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  frame_index;
		logic        evicted_valid;
		logic [2:0]  evicted_slot;
		logic [9:0]  evicted_page;
		logic [19:0] base_address;
		logic [10:0] page_total;
		logic [4:0]  frames_freed;
	} rsp_t;
endpackage

// ===== hw/rtl/dpff_if.sv =====
// interface: valid/ready channel carrying one payload
interface dpff_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/demand_paging_fifo_frames.sv =====
// top level: demand paging over a shared frame pool with fifo replacement
// an access reads the page table, then on a miss scans for a free frame or evicts
// allocate scans the slots for a base, releasing a live slot first; free releases frames
// one transaction in flight: a new request is taken only after the last response is gone
// the frame, queue and slot scans walk one entry a cycle
// reset: clearing pass over the page table, registers back to 8 and 16
module demand_paging_fifo_frames #(
	parameter int FRAMES = 16,
	parameter int PROCS = 8,
	parameter int MAX_PAGES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	dpff_if.sink   req,
	dpff_if.source rsp,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);
	import dpff_pkg::*;

	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int PW = (PROCS > 1) ? $clog2(PROCS) : 1;
	localparam int VW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int AW = PW + VW;
	localparam int DEPTH = PROCS * MAX_PAGES;
	localparam int CW = $clog2(FRAMES + 1);

	// controller states
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DECODE = 4'd2;
	localparam logic [3:0] S_PTREAD = 4'd3;
	localparam logic [3:0] S_LOOKUP = 4'd4;
	localparam logic [3:0] S_RELEASE = 4'd5;
	localparam logic [3:0] S_COMPACT = 4'd6;
	localparam logic [3:0] S_BASE = 4'd7;
	localparam logic [3:0] S_EVICT = 4'd8;
	localparam logic [3:0] S_LOAD = 4'd9;
	localparam logic [3:0] S_OUT = 4'd10;

	// page table memory: resident bit and frame number per virtual page
	logic [FW:0] pt_mem [DEPTH];
	logic [FW:0] pt_rd_q;
	logic        pt_we;
	logic [AW-1:0] pt_wa, pt_ra;
	logic [FW:0] pt_wd;

	always_ff @(posedge clk) begin
		if (pt_we)
			pt_mem[pt_wa] <= pt_wd;
		pt_rd_q <= pt_mem[pt_ra];
	end

	// frame table and fifo of load order, small and scanned one entry a cycle
	logic [FRAMES-1:0] frame_used_q;
	logic [PW-1:0] frame_owner_q [FRAMES];
	logic [VW-1:0] frame_vpage_q [FRAMES];
	logic [FW-1:0] queue_q [FRAMES];
	logic [CW-1:0] qcount_q;

	// process table
	logic [PROCS-1:0] live_q;
	logic [10:0] pages_q [PROCS];
	logic [19:0] pend_q [PROCS];

	logic [4:0] lg2_q, nfr_q;
	logic [3:0] state_q;
	logic [AW:0] clr_q;
	logic [FW:0] idx_q;
	logic [CW-1:0] widx_q;
	logic [FW-1:0] victim_q;
	logic          vfound_q;
	req_t req_q;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic relfree_q; // release belongs to a free request
	logic [16:0] bytes_q;

	// effective register values
	logic [4:0] eff_lg2;
	logic [CW-1:0] eff_fr;
	always_comb begin
		eff_lg2 = (lg2_q < 5'd6) ? 5'd6 : ((lg2_q > 5'd16) ? 5'd16 : lg2_q);
		if (nfr_q == 5'd0)
			eff_fr = CW'(1);
		else if (32'(nfr_q) > FRAMES)
			eff_fr = CW'(FRAMES);
		else
			eff_fr = CW'(nfr_q);
	end

	// allocate size check
	logic [16:0] npages;
	logic size_ok;
	logic slot_ok;
	always_comb begin
		npages = req_q.alloc_bytes >> eff_lg2;
		size_ok = req_q.alloc_bytes >= 17'd64 && req_q.alloc_bytes >= (17'd1 << eff_lg2)
			&& req_q.alloc_bytes <= 17'd65536
			&& (req_q.alloc_bytes & (req_q.alloc_bytes - 17'd1)) == 17'd0
			&& 32'(npages) <= MAX_PAGES;
		slot_ok = 32'(req_q.process_slot) < PROCS;
	end

	logic [PW-1:0] slot;
	assign slot = PW'(req_q.process_slot);
	logic [FW-1:0] fi;
	assign fi = idx_q[FW-1:0];

	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	always_comb begin
		pt_we = 1'b0;
		pt_wa = req_q.process_slot[PW-1:0] * AW'(MAX_PAGES) + AW'(req_q.page_number);
		pt_wd = '0;
		pt_ra = pt_wa;
		if (state_q == S_CLEAR) begin
			pt_we = 1'b1;
			pt_wa = clr_q[AW-1:0];
		end else if (state_q == S_RELEASE || state_q == S_EVICT) begin
			// clear resident bit of the frame's page
			pt_wa = AW'(frame_owner_q[fi]) * AW'(MAX_PAGES) + AW'(frame_vpage_q[fi]);
			if (state_q == S_EVICT)
				pt_wa = AW'(frame_owner_q[victim_q]) * AW'(MAX_PAGES)
					+ AW'(frame_vpage_q[victim_q]);
			pt_we = (state_q == S_EVICT) ? vfound_q
				: (frame_used_q[fi] && frame_owner_q[fi] == slot);
		end else if (state_q == S_LOAD) begin
			pt_we = 1'b1;
			pt_wd = {1'b1, victim_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			rsp_valid_q <= 1'b0;
			live_q <= '0;
			frame_used_q <= '0;
			qcount_q <= '0;
			lg2_q <= 5'd8;
			nfr_q <= 5'd16;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_PAGE_LOG2)
					lg2_q <= cfg_data;
				else
					nfr_q <= cfg_data;
			end
			if (rsp_valid_q && rsp.ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == DEPTH - 1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid && req.ready) begin
						req_q <= req.data;
						rsp_q <= '0;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					idx_q <= '0;
					relfree_q <= req_q.mode == MODE_FREE;
					bytes_q <= req_q.alloc_bytes;
					unique case (req_q.mode)
						MODE_ALLOC: begin
							if (!slot_ok) begin
								rsp_q.status <= ST_NO_PROC;
								state_q <= S_OUT;
							end else if (!size_ok) begin
								rsp_q.status <= ST_BAD_SIZE;
								state_q <= S_OUT;
							end else if (live_q[slot]) begin
								state_q <= S_RELEASE;
							end else begin
								state_q <= S_BASE;
							end
						end
						MODE_ACCESS: begin
							if (!slot_ok || !live_q[slot]) begin
								rsp_q.status <= ST_NO_PROC;
								state_q <= S_OUT;
							end else if (11'(req_q.page_number) >= pages_q[slot]) begin
								rsp_q.status <= ST_BAD_PAGE;
								state_q <= S_OUT;
							end else begin
								state_q <= S_PTREAD;
							end
						end
						MODE_FREE: begin
							if (!slot_ok || !live_q[slot]) begin
								rsp_q.status <= ST_NO_PROC;
								state_q <= S_OUT;
							end else begin
								state_q <= S_RELEASE;
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_PTREAD: begin
					// memory read issued this cycle
					state_q <= S_LOOKUP;
					vfound_q <= 1'b0;
				end
				S_LOOKUP: begin
					// hit, else scan for lowest free frame below the pool size
					if (pt_rd_q[FW]) begin
						rsp_q.frame_index <= 4'(pt_rd_q[FW-1:0]);
						state_q <= S_OUT;
					end else if (CW'(idx_q) < eff_fr) begin
						if (!frame_used_q[fi]) begin
							victim_q <= fi;
							rsp_q.status <= ST_FAULT_FREE;
							state_q <= S_LOAD;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						// no free frame: pick earliest loaded in the queue below pool size
						rsp_q.status <= ST_FAULT_EVICT;
						idx_q <= '0;
						state_q <= S_EVICT;
					end
				end
				S_EVICT: begin
					// scan queue; pt write above uses victim_q only on the final cycle
					if (vfound_q) begin
						frame_used_q[victim_q] <= 1'b0;
						rsp_q.evicted_valid <= 1'b1;
						rsp_q.evicted_slot <= 3'(frame_owner_q[victim_q]);
						rsp_q.evicted_page <= 10'(frame_vpage_q[victim_q]);
						idx_q <= '0;
						widx_q <= '0;
						relfree_q <= 1'b0;
						state_q <= S_COMPACT;
					end else if (CW'(idx_q) < qcount_q
						&& CW'(queue_q[fi]) < eff_fr) begin
						victim_q <= queue_q[fi];
						vfound_q <= 1'b1;
					end else if (CW'(idx_q) < qcount_q) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						// queue holds nothing usable; frame 0 is reused without eviction
						victim_q <= '0;
						state_q <= S_LOAD;
					end
				end
				S_RELEASE: begin
					if (frame_used_q[fi] && frame_owner_q[fi] == slot) begin
						frame_used_q[fi] <= 1'b0;
						rsp_q.frames_freed <= rsp_q.frames_freed + 5'd1;
					end
					if (32'(idx_q) == FRAMES - 1) begin
						idx_q <= '0;
						widx_q <= '0;
						live_q[slot] <= 1'b0;
						state_q <= S_COMPACT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_COMPACT: begin
					if (CW'(idx_q) < qcount_q) begin
						if (frame_used_q[queue_q[fi]]) begin
							queue_q[widx_q[FW-1:0]] <= queue_q[fi];
							widx_q <= widx_q + 1'b1;
						end
						idx_q <= idx_q + 1'b1;
					end else begin
						qcount_q <= widx_q;
						idx_q <= '0;
						if (req_q.mode == MODE_ACCESS)
							state_q <= S_LOAD;
						else if (relfree_q)
							state_q <= S_OUT;
						else
							state_q <= S_BASE;
					end
				end
				S_BASE: begin
					// highest end of the live processes
					if (live_q[idx_q[PW-1:0]] && pend_q[idx_q[PW-1:0]] > rsp_q.base_address)
						rsp_q.base_address <= pend_q[idx_q[PW-1:0]];
					if (32'(idx_q) == PROCS - 1) begin
						state_q <= S_OUT;
						live_q[slot] <= 1'b1;
						pages_q[slot] <= 11'(npages);
						rsp_q.page_total <= 11'(npages);
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_LOAD: begin
					frame_used_q[victim_q] <= 1'b1;
					frame_owner_q[victim_q] <= slot;
					frame_vpage_q[victim_q] <= VW'(req_q.page_number);
					if (32'(qcount_q) < FRAMES) begin
						queue_q[qcount_q[FW-1:0]] <= victim_q;
						qcount_q <= qcount_q + 1'b1;
					end
					rsp_q.frame_index <= 4'(victim_q);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (req_q.mode == MODE_ALLOC && rsp_q.status == ST_OK)
						pend_q[slot] <= rsp_q.base_address + 20'(bytes_q);
					rsp_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== dv/tb_demand_paging_fifo_frames.sv =====
// testbench for the demand paging frame block with fifo replacement
`timescale 1ns / 100ps

module tb_demand_paging_fifo_frames;
	import dpff_pkg::*;

	localparam int FRAMES = 16;
	localparam int PROCS = 8;
	localparam int MAX_PAGES = 1024;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [1:0] MODE_IGNORED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [4:0] cfg_data = '0;

	dpff_if #(.T(req_t)) req_ch ();
	dpff_if #(.T(rsp_t)) rsp_ch ();

	demand_paging_fifo_frames #(
		.FRAMES(FRAMES), .PROCS(PROCS), .MAX_PAGES(MAX_PAGES)
	) DUT (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state, a private copy of the block's tables
	logic [4:0]  pg_log2_reg, frames_reg;
	bit          slot_live [PROCS];
	int unsigned slot_pages [PROCS];
	int unsigned slot_bytes [PROCS];
	int unsigned slot_base [PROCS];
	bit          vpage_res [PROCS*MAX_PAGES];
	int unsigned vpage_frame [PROCS*MAX_PAGES];
	bit          frm_used [FRAMES];
	int unsigned frm_owner [FRAMES];
	int unsigned frm_vpage [FRAMES];
	int unsigned fifo_order [FRAMES];
	int unsigned fifo_len;

	rsp_t expected_rsp [$];
	int   err_count = 0;
	int   cycle_count = 0;
	bit   idle_on = 1'b1;

	// directed row: request plus an optional typed-in answer
	typedef struct {
		req_t r;
		bit   typed;
		rsp_t e;
	} row_t;
	row_t dir_rows [$];

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report(string fld, int unsigned got, int unsigned exp);
		$display("mismatch %s: got %0d expected %0d (t=%0t)", fld, got, exp, $realtime);
		err_count++;
	endtask

	// keep only in-use frames in the load order
	function automatic void squeeze_fifo();
		int unsigned w;
		w = 0;
		for (int r = 0; r < fifo_len && r < FRAMES; r++)
			if (frm_used[fifo_order[r]]) begin
				fifo_order[w] = fifo_order[r];
				w++;
			end
		fifo_len = w;
	endfunction

	function automatic int unsigned drop_slot(int unsigned s);
		int unsigned n;
		n = 0;
		for (int f = 0; f < FRAMES; f++)
			if (frm_used[f] && frm_owner[f] == s) begin
				vpage_res[s*MAX_PAGES + frm_vpage[f]] = 1'b0;
				frm_used[f] = 1'b0;
				n++;
			end
		squeeze_fifo();
		slot_live[s] = 1'b0;
		return n;
	endfunction

	function automatic void clear_tables();
		pg_log2_reg = 5'd8;
		frames_reg = 5'd16;
		foreach (slot_live[i]) slot_live[i] = 1'b0;
		foreach (vpage_res[i]) vpage_res[i] = 1'b0;
		foreach (frm_used[i]) frm_used[i] = 1'b0;
		fifo_len = 0;
	endfunction

	// works out the answer to one accepted transaction and updates the tables
	function automatic rsp_t page_table_step(req_t r);
		rsp_t o;
		int unsigned lg, psz, b, s, p, idx, cnt, f, vb, e;
		bit ok, found;
		o = '0;
		s = r.process_slot;
		b = r.alloc_bytes;
		p = r.page_number;
		case (r.mode)
			MODE_ALLOC: begin
				lg = (pg_log2_reg < 6) ? 6 : (pg_log2_reg > 16) ? 16 : pg_log2_reg;
				psz = 1 << lg;
				ok = b >= 64 && b >= psz && b <= 65536 && (b & (b - 1)) == 0;
				if (!ok || (b >> lg) > MAX_PAGES) begin
					o.status = ST_BAD_SIZE;
				end else begin
					// a live slot is released before its new extent is placed
					if (slot_live[s]) o.frames_freed = 5'(drop_slot(s));
					vb = 0;
					for (int i = 0; i < PROCS; i++)
						if (slot_live[i]) begin
							e = (slot_base[i] + slot_bytes[i]) & 20'hFFFFF;
							if (e > vb) vb = e;
						end
					slot_live[s] = 1'b1;
					slot_pages[s] = b >> lg;
					slot_bytes[s] = b;
					slot_base[s] = vb;
					o.base_address = 20'(vb);
					o.page_total = 11'(b >> lg);
				end
			end
			MODE_ACCESS: begin
				idx = s*MAX_PAGES + p;
				if (!slot_live[s]) begin
					o.status = ST_NO_PROC;
				end else if (p >= slot_pages[s]) begin
					o.status = ST_BAD_PAGE;
				end else if (vpage_res[idx]) begin
					o.frame_index = 4'(vpage_frame[idx]);
				end else begin
					cnt = (frames_reg < 1) ? 1 : (frames_reg > FRAMES) ? FRAMES : frames_reg;
					found = 1'b0;
					f = 0;
					for (int i = 0; i < cnt && !found; i++)
						if (!frm_used[i]) begin
							found = 1'b1;
							f = i;
						end
					if (found) begin
						o.status = ST_FAULT_FREE;
					end else begin
						// oldest loaded frame inside the current pool is the victim
						o.status = ST_FAULT_EVICT;
						f = 0;
						for (int q = 0; q < fifo_len; q++)
							if (fifo_order[q] < cnt) begin
								f = fifo_order[q];
								break;
							end
						o.evicted_valid = 1'b1;
						o.evicted_slot = 3'(frm_owner[f]);
						o.evicted_page = 10'(frm_vpage[f]);
						vpage_res[frm_owner[f]*MAX_PAGES + frm_vpage[f]] = 1'b0;
						frm_used[f] = 1'b0;
						squeeze_fifo();
					end
					frm_used[f] = 1'b1;
					frm_owner[f] = s;
					frm_vpage[f] = p;
					vpage_res[idx] = 1'b1;
					vpage_frame[idx] = f;
					if (fifo_len < FRAMES) begin
						fifo_order[fifo_len] = f;
						fifo_len++;
					end
					o.frame_index = 4'(f);
				end
			end
			MODE_FREE: begin
				if (!slot_live[s]) o.status = ST_NO_PROC;
				else o.frames_freed = 5'(drop_slot(s));
			end
			default: ;
		endcase
		return o;
	endfunction

	// drive one request at the falling edge and hold it until accepted
	task automatic send_req(req_t r, bit typed, rsp_t e);
		int gap;
		rsp_t pr;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.data = r;
		req_ch.valid = 1'b1;
		forever begin
			@(posedge clk);
			if (req_ch.ready) break;
		end
		pr = page_table_step(r);
		expected_rsp = {expected_rsp, (typed ? e : pr)};
		@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [4:0] val);
		req_ch.valid = 1'b0;
		while (expected_rsp.size() != 0) @(negedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		if (idx == REG_PAGE_LOG2) pg_log2_reg = val;
		else frames_reg = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic req_t mk(logic [1:0] m, int s, int b, int p);
		req_t r;
		r.mode = m;
		r.process_slot = 3'(s);
		r.alloc_bytes = 17'(b);
		r.page_number = 10'(p);
		return r;
	endfunction

	function automatic void add_row(req_t r, bit typed, rsp_t e);
		row_t w;
		w.r = r;
		w.typed = typed;
		w.e = e;
		dir_rows = {dir_rows, w};
	endfunction

	// mostly well-formed traffic, with small page numbers when the slot is live
	function automatic req_t rand_req();
		req_t r;
		int k, s, lim;
		r = req_t'($urandom);
		k = $urandom_range(0, 99);
		s = r.process_slot;
		if (k < 14) begin
			r.mode = MODE_ALLOC;
			if ($urandom_range(0, 5) != 0) r.alloc_bytes = 17'(1 << $urandom_range(6, 16));
		end else if (k < 86) begin
			r.mode = MODE_ACCESS;
			if (slot_live[s] && $urandom_range(0, 9) != 0) begin
				lim = slot_pages[s] - 1;
				if (lim > 24) lim = 24;
				r.page_number = 10'($urandom_range(0, lim));
			end
		end else if (k < 96) begin
			r.mode = MODE_FREE;
		end else begin
			r.mode = MODE_IGNORED;
		end
		return r;
	endfunction

	// response side: random ready bursts, check in order
	int ready_hold = 0;
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			rsp_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			ready_hold <= $urandom_range(0, 18);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		rsp_t g, x;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			g = rsp_ch.data;
			if (expected_rsp.size() == 0) begin
				$display("unexpected response transaction (t=%0t)", $realtime);
				err_count++;
			end else begin
				x = expected_rsp.pop_front();
				if (g.status !== x.status) report("status", g.status, x.status);
				if (g.frame_index !== x.frame_index)
					report("frame_index", g.frame_index, x.frame_index);
				if (g.evicted_valid !== x.evicted_valid)
					report("evicted_valid", g.evicted_valid, x.evicted_valid);
				if (g.evicted_slot !== x.evicted_slot)
					report("evicted_slot", g.evicted_slot, x.evicted_slot);
				if (g.evicted_page !== x.evicted_page)
					report("evicted_page", g.evicted_page, x.evicted_page);
				if (g.base_address !== x.base_address)
					report("base_address", g.base_address, x.base_address);
				if (g.page_total !== x.page_total)
					report("page_total", g.page_total, x.page_total);
				if (g.frames_freed !== x.frames_freed)
					report("frames_freed", g.frames_freed, x.frames_freed);
			end
		end
	end

	initial begin
		rsp_t z, t;
		logic [4:0] lg_set [6];
		logic [4:0] fr_set [6];
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		clear_tables();
		z = '0;

		// directed rows: typed answers only where they are obvious
		t = z; t.status = ST_BAD_SIZE;
		add_row(mk(MODE_ALLOC, 0, 0, 0), 1, t);
		t = z; t.page_total = 11'd256;
		add_row(mk(MODE_ALLOC, 0, 65536, 0), 1, t);
		t = z; t.status = ST_FAULT_FREE;
		add_row(mk(MODE_ACCESS, 0, 0, 0), 1, t);
		add_row(mk(MODE_ACCESS, 0, 0, 0), 1, z);
		t = z; t.status = ST_NO_PROC;
		add_row(mk(MODE_ACCESS, 1, 0, 5), 1, t);
		add_row(mk(MODE_FREE, 3, 0, 0), 1, t);
		t = z; t.status = ST_BAD_PAGE;
		add_row(mk(MODE_ACCESS, 0, 0, 256), 1, t);
		add_row(mk(MODE_ACCESS, 0, 131071, 1023), 1, t);
		// ignored mode answers all zero
		add_row(mk(MODE_IGNORED, 7, 131071, 1023), 1, z);
		t = z; t.status = ST_BAD_SIZE;
		add_row(mk(MODE_ALLOC, 1, 128, 0), 1, t);
		add_row(mk(MODE_ALLOC, 1, 65535, 0), 1, t);
		add_row(mk(MODE_ALLOC, 1, 131071, 0), 1, t);
		add_row(mk(MODE_ALLOC, 0, 96, 0), 1, t);
		t = z; t.base_address = 20'd65536; t.page_total = 11'd1;
		add_row(mk(MODE_ALLOC, 7, 256, 0), 1, t);
		add_row(mk(MODE_ACCESS, 7, 0, 0), 0, z);
		for (int p = 1; p < 5; p++) add_row(mk(MODE_ACCESS, 0, 0, p), 0, z);
		add_row(mk(MODE_ACCESS, 0, 0, 255), 0, z);
		// reallocating a live slot frees its frames first
		add_row(mk(MODE_ALLOC, 0, 1024, 0), 0, z);
		add_row(mk(MODE_ALLOC, 2, 256, 0), 0, z);
		add_row(mk(MODE_FREE, 7, 0, 0), 0, z);
		add_row(mk(MODE_ALLOC, 3, 256, 0), 0, z);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) send_req(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);

		// register settings per random phase, extremes and out-of-range values
		lg_set = '{5'd6, 5'd16, 5'd0, 5'd31, 5'd10, 5'd8};
		fr_set = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd16};
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_PAGE_LOG2, lg_set[ph]);
			write_reg(REG_FRAMES, fr_set[ph]);
			// last phase runs with both sides always ready
			if (ph == 5) idle_on = 1'b0;
			repeat (75) send_req(rand_req(), 0, z);
		end
		req_ch.valid = 1'b0;

		while (expected_rsp.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
